// ----- design/ptp_slm_pkg.sv -----
// shared constants, types and codes of the peak-to-peak sound level meter
`default_nettype none

package ptp_slm_pkg;

    // sample and calibration sizing
    localparam int SAMPLE_BITS     = 12;
    localparam int MAX_CAL_WINDOWS = 1024;
    localparam int CNT_W           = $clog2(MAX_CAL_WINDOWS + 1);
    localparam int SUM_W           = SAMPLE_BITS + $clog2(MAX_CAL_WINDOWS);

    // result field widths
    localparam int REF_W   = 16;
    localparam int LEVEL_W = 15;

    // log2 unit sizing: amplitude is scaled to Q4 before the log
    localparam int AMP_Q_W  = SAMPLE_BITS + 4;
    localparam int LOG_IN_W = (AMP_Q_W > REF_W) ? AMP_Q_W : REF_W;
    localparam int EXP_W    = $clog2(LOG_IN_W);
    localparam int FRAC_W   = 16;
    localparam int MANT_W   = 16;
    localparam int LOG_W    = EXP_W + FRAC_W;

    // dB scaling: round(20*log10(2) * 2^16)
    localparam int                DB_W        = 19;
    localparam logic [DB_W-1:0]   DB_PER_LOG2 = 19'd394566;
    localparam int                PROD_W      = LOG_W + DB_W;
    localparam int                RND_SHIFT   = 24;

    // calibration divider: dividend is sum*16 + count/2
    localparam int DIVN_W   = SUM_W + 5;
    localparam int ITER_MAX = (DIVN_W > FRAC_W) ? DIVN_W : FRAC_W;
    localparam int ITER_W   = $clog2(ITER_MAX);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [REF_W-1:0]       REF_RESET  = 16'd480;
    localparam logic [REF_W-1:0]       REF_ONE    = 16'd16;
    localparam logic [REF_W-1:0]       REF_SAT    = '1;
    localparam logic [LEVEL_W-1:0]     LEVEL_SAT  = '1;

    // item mode codes
    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_CAL_ADD = 2'd1,
        MODE_CAL_END = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LA_LOAD,
        S_LA_ITER,
        S_LR_LOAD,
        S_LR_ITER,
        S_DIFF,
        S_MUL,
        S_RND,
        S_DIV_LOAD,
        S_DIV_ITER,
        S_DIV_FIN,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic upd_win;
        logic close_win;
        logic cal_add;
        logic meas_start;
        logic log_load;
        logic log_sel_ref;
        logic log_step;
        logic la_save;
        logic diff;
        logic mul;
        logic rnd;
        logic div_load;
        logic div_step;
        logic div_fin;
        logic out_load;
        logic out_is_cal;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cal_empty;
    } t_status;

endpackage

`default_nettype wire

// ----- design/ptp_slm_dp.sv -----
// datapath: window min/max, calibration sum, log2 unit, dB scaling, divider, result register
`default_nettype none

module ptp_slm_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [ptp_slm_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  wire ptp_slm_pkg::t_cmd                      i_cmd,
    output ptp_slm_pkg::t_status                        o_status,
    output logic [ptp_slm_pkg::SAMPLE_BITS-1:0]         o_amplitude,
    output logic [ptp_slm_pkg::LEVEL_W-1:0]             o_level_db,
    output logic [ptp_slm_pkg::REF_W-1:0]               o_reference,
    output logic                                        o_is_calibration
);

    localparam int SB = ptp_slm_pkg::SAMPLE_BITS;
    localparam int LI = ptp_slm_pkg::LOG_IN_W;
    localparam int EW = ptp_slm_pkg::EXP_W;
    localparam int FW = ptp_slm_pkg::FRAC_W;
    localparam int MW = ptp_slm_pkg::MANT_W;
    localparam int LW = ptp_slm_pkg::LOG_W;
    localparam int PW = ptp_slm_pkg::PROD_W;
    localparam int RS = ptp_slm_pkg::RND_SHIFT;
    localparam int LV = ptp_slm_pkg::LEVEL_W;
    localparam int RW = ptp_slm_pkg::REF_W;
    localparam int CW = ptp_slm_pkg::CNT_W;
    localparam int SW = ptp_slm_pkg::SUM_W;
    localparam int DW = ptp_slm_pkg::DIVN_W;
    localparam logic [PW:0] RND_HALF = (PW + 1)'(1) << (RS - 1);

    // architectural state
    logic [SB-1:0] r_win_max, r_win_min;
    logic [SW-1:0] r_cal_sum;
    logic [CW-1:0] r_cal_cnt;
    logic [RW-1:0] r_ref;

    // work registers
    logic [SB-1:0] r_amp;
    logic [MW-1:0] r_lg_m;
    logic [EW-1:0] r_lg_e;
    logic [FW-1:0] r_lg_frac;
    logic [LW-1:0] r_la;
    logic [LW-1:0] r_diff;
    logic [PW-1:0] r_prod;
    logic [LV-1:0] r_level;
    logic [DW-1:0] r_div_q;
    logic [CW-1:0] r_div_r;

    // result register
    logic [SB-1:0] r_out_amp;
    logic [LV-1:0] r_out_level;
    logic [RW-1:0] r_out_ref;
    logic          r_out_cal;

    // combinational values
    logic [SB-1:0]   w_max, w_min, w_raw;
    logic [LI-1:0]   lg_in, lg_norm;
    logic [EW-1:0]   lg_e;
    logic [MW-1:0]   lg_mant;
    logic [2*MW-1:0] sq_full;
    logic [MW:0]     sq;
    logic            sq_bit;
    logic [MW-1:0]   m_next;
    logic [LW-1:0]   lr;
    logic [PW:0]     rnd_sum;
    logic [PW-RS:0]  rnd_q;
    logic [CW:0]     trial, trial_sub;
    logic            trial_ge;

    // min/max including the current sample, and window amplitude
    always_comb begin
        w_max = (i_sample > r_win_max) ? i_sample : r_win_max;
        w_min = (i_sample < r_win_min) ? i_sample : r_win_min;
        w_raw = (w_max >= w_min) ? (w_max - w_min) : '0;
    end

    // window tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_max <= '0;
            r_win_min <= ptp_slm_pkg::SAMPLE_MAX;
        end else if (i_cmd.upd_win) begin
            if (i_cmd.close_win) begin
                r_win_max <= '0;
                r_win_min <= ptp_slm_pkg::SAMPLE_MAX;
            end else begin
                r_win_max <= w_max;
                r_win_min <= w_min;
            end
        end
    end

    // calibration accumulator, cleared when calibration finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_sum <= '0;
            r_cal_cnt <= '0;
        end else if (i_cmd.div_fin) begin
            r_cal_sum <= '0;
            r_cal_cnt <= '0;
        end else if (i_cmd.cal_add && (r_cal_cnt < CW'(ptp_slm_pkg::MAX_CAL_WINDOWS))) begin
            r_cal_sum <= r_cal_sum + SW'(w_raw);
            r_cal_cnt <= r_cal_cnt + 1'b1;
        end
    end

    assign o_status.cal_empty = (r_cal_cnt == '0);

    // amplitude of a closed measure window, floored at one
    always_ff @(posedge i_clk) begin
        if (i_cmd.meas_start) begin
            r_amp <= (w_raw == '0) ? SB'(1) : w_raw;
        end
    end

    // log2 load: msb position and mantissa normalized to [1,2) in Q15
    always_comb begin
        lg_e  = '0;
        lg_in = i_cmd.log_sel_ref ? LI'(r_ref) : LI'({r_amp, 4'b0000});
        for (int k = 0; k < LI; k++) begin
            if (lg_in[k]) lg_e = EW'(k);
        end
        lg_norm = lg_in << (EW'(LI - 1) - lg_e);
        lg_mant = lg_norm[LI-1 -: MW];
    end

    // one fraction bit per squaring
    always_comb begin
        sq_full = r_lg_m * r_lg_m;
        sq      = sq_full[2*MW-1:MW-1];
        sq_bit  = sq[MW];
        m_next  = sq_bit ? sq[MW:1] : sq[MW-1:0];
    end

    // log2 unit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.log_load) begin
            r_lg_e    <= lg_e;
            r_lg_m    <= lg_mant;
            r_lg_frac <= '0;
        end else if (i_cmd.log_step) begin
            r_lg_m    <= m_next;
            r_lg_frac <= {r_lg_frac[FW-2:0], sq_bit};
        end
        if (i_cmd.la_save) begin
            r_la <= {r_lg_e, r_lg_frac};
        end
    end

    // dB scaling: difference, multiply, round and saturate
    always_comb begin
        lr      = {r_lg_e, r_lg_frac};
        rnd_sum = {1'b0, r_prod} + RND_HALF;
        rnd_q   = rnd_sum[PW:RS];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_diff <= (r_la > lr) ? (r_la - lr) : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_diff) * PW'(ptp_slm_pkg::DB_PER_LOG2);
        end
        if (i_cmd.rnd) begin
            r_level <= (rnd_q > (PW - RS + 1)'(ptp_slm_pkg::LEVEL_SAT)) ?
                       ptp_slm_pkg::LEVEL_SAT : rnd_q[LV-1:0];
        end
    end

    // restoring divider step
    always_comb begin
        trial     = {r_div_r, r_div_q[DW-1]};
        trial_ge  = (trial >= {1'b0, r_cal_cnt});
        trial_sub = trial - {1'b0, r_cal_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_q <= (DW'(r_cal_sum) << 4) + DW'(r_cal_cnt >> 1);
            r_div_r <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q <= {r_div_q[DW-2:0], trial_ge};
            r_div_r <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
        end
    end

    // reference amplitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= ptp_slm_pkg::REF_RESET;
        end else if (i_cmd.div_fin) begin
            if (r_cal_cnt == '0) begin
                r_ref <= ptp_slm_pkg::REF_ONE;
            end else if (r_div_q < DW'(ptp_slm_pkg::REF_ONE)) begin
                r_ref <= ptp_slm_pkg::REF_ONE;
            end else if (r_div_q > DW'(ptp_slm_pkg::REF_SAT)) begin
                r_ref <= ptp_slm_pkg::REF_SAT;
            end else begin
                r_ref <= r_div_q[RW-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_amp   <= i_cmd.out_is_cal ? '0 : r_amp;
            r_out_level <= i_cmd.out_is_cal ? '0 : r_level;
            r_out_ref   <= r_ref;
            r_out_cal   <= i_cmd.out_is_cal;
        end
    end

    assign o_amplitude      = r_out_amp;
    assign o_level_db       = r_out_level;
    assign o_reference      = r_out_ref;
    assign o_is_calibration = r_out_cal;

endmodule

`default_nettype wire

// ----- design/ptp_slm_ctrl.sv -----
// controller: item handshake, sequencing of log, scaling and divide steps, result valid
`default_nettype none

module ptp_slm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_last_in_window,
    input  wire logic [1:0]           i_mode,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    input  wire ptp_slm_pkg::t_status i_status,
    output ptp_slm_pkg::t_cmd         o_cmd
);

    localparam int IW = ptp_slm_pkg::ITER_W;

    ptp_slm_pkg::t_state r_state, n_state;
    logic [IW-1:0]       r_cnt, n_cnt;
    logic                r_is_cal, n_is_cal;
    logic                r_out_valid, n_out_valid;

    ptp_slm_pkg::t_mode  w_mode;
    logic                fire, out_free, cnt_zero;

    assign w_mode   = ptp_slm_pkg::t_mode'(i_mode);
    assign fire     = i_valid && (r_state == ptp_slm_pkg::S_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign cnt_zero = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptp_slm_pkg::S_IDLE: begin
                if (fire) begin
                    case (w_mode)
                        ptp_slm_pkg::MODE_MEASURE: begin
                            if (i_last_in_window) n_state = ptp_slm_pkg::S_LA_LOAD;
                        end
                        ptp_slm_pkg::MODE_CAL_END: begin
                            n_state = i_status.cal_empty ? ptp_slm_pkg::S_DIV_FIN :
                                                           ptp_slm_pkg::S_DIV_LOAD;
                        end
                        default: n_state = ptp_slm_pkg::S_IDLE;
                    endcase
                end
            end
            ptp_slm_pkg::S_LA_LOAD:  n_state = ptp_slm_pkg::S_LA_ITER;
            ptp_slm_pkg::S_LA_ITER: begin
                if (cnt_zero) n_state = ptp_slm_pkg::S_LR_LOAD;
            end
            ptp_slm_pkg::S_LR_LOAD:  n_state = ptp_slm_pkg::S_LR_ITER;
            ptp_slm_pkg::S_LR_ITER: begin
                if (cnt_zero) n_state = ptp_slm_pkg::S_DIFF;
            end
            ptp_slm_pkg::S_DIFF:     n_state = ptp_slm_pkg::S_MUL;
            ptp_slm_pkg::S_MUL:      n_state = ptp_slm_pkg::S_RND;
            ptp_slm_pkg::S_RND:      n_state = ptp_slm_pkg::S_DONE;
            ptp_slm_pkg::S_DIV_LOAD: n_state = ptp_slm_pkg::S_DIV_ITER;
            ptp_slm_pkg::S_DIV_ITER: begin
                if (cnt_zero) n_state = ptp_slm_pkg::S_DIV_FIN;
            end
            ptp_slm_pkg::S_DIV_FIN:  n_state = ptp_slm_pkg::S_DONE;
            ptp_slm_pkg::S_DONE: begin
                if (out_free) n_state = ptp_slm_pkg::S_IDLE;
            end
            default: n_state = ptp_slm_pkg::S_IDLE;
        endcase
    end

    // iteration counter
    always_comb begin
        case (r_state)
            ptp_slm_pkg::S_LA_LOAD,
            ptp_slm_pkg::S_LR_LOAD:  n_cnt = IW'(ptp_slm_pkg::FRAC_W - 1);
            ptp_slm_pkg::S_DIV_LOAD: n_cnt = IW'(ptp_slm_pkg::DIVN_W - 1);
            ptp_slm_pkg::S_LA_ITER,
            ptp_slm_pkg::S_LR_ITER,
            ptp_slm_pkg::S_DIV_ITER: n_cnt = r_cnt - 1'b1;
            default:                 n_cnt = r_cnt;
        endcase
    end

    // result kind and result valid
    always_comb begin
        n_is_cal    = fire ? (w_mode == ptp_slm_pkg::MODE_CAL_END) : r_is_cal;
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.out_is_cal = r_is_cal;
        case (r_state)
            ptp_slm_pkg::S_IDLE: begin
                o_cmd.upd_win    = fire && ((w_mode == ptp_slm_pkg::MODE_MEASURE) ||
                                            (w_mode == ptp_slm_pkg::MODE_CAL_ADD));
                o_cmd.close_win  = o_cmd.upd_win && i_last_in_window;
                o_cmd.cal_add    = o_cmd.close_win && (w_mode == ptp_slm_pkg::MODE_CAL_ADD);
                o_cmd.meas_start = o_cmd.close_win && (w_mode == ptp_slm_pkg::MODE_MEASURE);
            end
            ptp_slm_pkg::S_LA_LOAD: begin
                o_cmd.log_load = 1'b1;
            end
            ptp_slm_pkg::S_LA_ITER,
            ptp_slm_pkg::S_LR_ITER: begin
                o_cmd.log_step = 1'b1;
            end
            ptp_slm_pkg::S_LR_LOAD: begin
                o_cmd.la_save     = 1'b1;
                o_cmd.log_load    = 1'b1;
                o_cmd.log_sel_ref = 1'b1;
            end
            ptp_slm_pkg::S_DIFF:     o_cmd.diff     = 1'b1;
            ptp_slm_pkg::S_MUL:      o_cmd.mul      = 1'b1;
            ptp_slm_pkg::S_RND:      o_cmd.rnd      = 1'b1;
            ptp_slm_pkg::S_DIV_LOAD: o_cmd.div_load = 1'b1;
            ptp_slm_pkg::S_DIV_ITER: o_cmd.div_step = 1'b1;
            ptp_slm_pkg::S_DIV_FIN:  o_cmd.div_fin  = 1'b1;
            ptp_slm_pkg::S_DONE:     o_cmd.out_load = out_free;
            default:                 o_cmd = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptp_slm_pkg::S_IDLE;
            r_cnt       <= '0;
            r_is_cal    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_is_cal    <= n_is_cal;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ptp_slm_pkg::S_IDLE);
    assign o_valid = r_out_valid;

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // a closing measure item starts the log sequence
    a_meas_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (w_mode == ptp_slm_pkg::MODE_MEASURE) && i_last_in_window)
        |=> (r_state == ptp_slm_pkg::S_LA_LOAD))
        else $error("measure window close did not start log");

    // the amplitude log ends after its last fraction bit
    a_log_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ptp_slm_pkg::S_LA_ITER) && cnt_zero)
        |=> (r_state == ptp_slm_pkg::S_LR_LOAD))
        else $error("amplitude log did not hand over to reference log");

    // a new result only appears from the done state
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ptp_slm_pkg::S_DONE))
        else $error("result valid raised outside done state");

endmodule

`default_nettype wire

// ----- design/peak_to_peak_sound_level_meter.sv -----
// top level of the peak-to-peak sound level meter
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------------
//  input   | i_valid | o_ready | i_sample, i_last_in_window, i_mode
//  result  | o_valid | i_ready | o_amplitude, o_level_db, o_reference, o_is_calibration
//
// a sample that does not close a measure window, or a mode three item, is handled in idle
// a closing measure item runs two 16-step log2 passes on the shared squarer,
// then difference, dB multiply and rounding, then the result register load
// a finish-calibration item runs the 27-step restoring divider
// (skipped with no calibration windows); reset is synchronous, no clearing pass
// a waiting result does not block input items that give no result
`default_nettype none

module peak_to_peak_sound_level_meter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [ptp_slm_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  wire logic                                   i_last_in_window,
    input  wire logic [1:0]                             i_mode,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [ptp_slm_pkg::SAMPLE_BITS-1:0]         o_amplitude,
    output logic [ptp_slm_pkg::LEVEL_W-1:0]             o_level_db,
    output logic [ptp_slm_pkg::REF_W-1:0]               o_reference,
    output logic                                        o_is_calibration
);

    ptp_slm_pkg::t_cmd    cmd;
    ptp_slm_pkg::t_status status;

    // sequencing
    ptp_slm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_last_in_window (i_last_in_window),
        .i_mode           (i_mode),
        .o_ready          (o_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    // arithmetic and state
    ptp_slm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_amplitude      (o_amplitude),
        .o_level_db       (o_level_db),
        .o_reference      (o_reference),
        .o_is_calibration (o_is_calibration)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for the peak-to-peak sound level meter
module testbench;

    import ptp_slm_pkg::*;

    localparam int          HALF_PERIOD     = 1;
    localparam int          RESET_CYCLES    = 9;
    localparam int          QUIET_LIMIT     = 4000;
    localparam int          DRAIN_CYCLES    = 60;
    localparam int          LONG_HOLD       = 400;
    localparam int          MAX_REPORTS     = 10;
    localparam int          CAL_WINDOW_CAP  = 1024;
    localparam int          CAL_FILL_WINDOWS = 1030;
    localparam int          CAL_WIDE_WINDOWS = 6;
    localparam logic [63:0] DB_PER_OCTAVE   = 64'd394566;
    localparam int unsigned REF_AT_RESET    = 480;
    localparam int unsigned REF_UNITY       = 16;
    localparam int unsigned LEVEL_CEILING   = 32767;

    // one result item of the meter
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] amplitude;
        logic [LEVEL_W-1:0]     level_db;
        logic [REF_W-1:0]       reference;
        logic                   is_calibration;
    } meter_reading_t;

    // one row of the directed stimulus table
    typedef struct {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        t_mode                  mode;
        bit                     typed;
        meter_reading_t         want;
    } stim_row_t;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample         = '0;
    logic                   i_last_in_window = 1'b0;
    t_mode                  i_mode           = MODE_MEASURE;
    logic                   i_ready          = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [SAMPLE_BITS-1:0] o_amplitude;
    logic [LEVEL_W-1:0]     o_level_db;
    logic [REF_W-1:0]       o_reference;
    logic                   o_is_calibration;

    // stimulus pacing and long receiver hold-off
    int unsigned tx_idle_pct     = 23;
    int unsigned rx_idle_pct     = 48;
    logic        long_hold_req   = 1'b0;
    logic        long_hold_taken = 1'b0;
    int unsigned hold_left       = 0;
    int unsigned quiet_cycles    = 0;

    int unsigned items_sent      = 0;
    int unsigned mismatch_count  = 0;

    meter_reading_t pending_readings[$];
    stim_row_t      directed_rows[$];

    // predictor state
    logic [SAMPLE_BITS-1:0] win_hi;
    logic [SAMPLE_BITS-1:0] win_lo;
    int unsigned            cal_total;
    int unsigned            cal_windows;
    logic [REF_W-1:0]       ref_q4;

    peak_to_peak_sound_level_meter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_last_in_window (i_last_in_window),
        .i_mode           (i_mode),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_amplitude      (o_amplitude),
        .o_level_db       (o_level_db),
        .o_reference      (o_reference),
        .o_is_calibration (o_is_calibration)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // log2 in Q16 by repeated squaring of the normalized mantissa
    function automatic logic [31:0] log2_fixed(input logic [31:0] v);
        int unsigned     e;
        logic [31:0]     m;
        logic [63:0]     sq;
        logic [15:0]     frac;
        e = 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        m = (e <= 15) ? (v << (15 - e)) : (v >> (e - 15));
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            sq = ({32'd0, m} * {32'd0, m}) >> 15;
            frac = {frac[14:0], 1'b0};
            if (sq >= 64'd65536) begin
                frac[0] = 1'b1;
                sq = sq >> 1;
            end
            m = sq[31:0];
        end
        return {e[15:0], frac};
    endfunction

    // dB level of an amplitude against a Q4 reference, Q7.8, clamped at zero
    function automatic logic [LEVEL_W-1:0] db_level(input logic [SAMPLE_BITS-1:0] amp,
                                                    input logic [REF_W-1:0] refq4);
        logic [31:0] la;
        logic [31:0] lr;
        logic [63:0] scaled;
        la = log2_fixed({16'd0, amp, 4'd0});
        lr = log2_fixed((refq4 == '0) ? 32'd1 : {16'd0, refq4});
        if (la <= lr) return '0;
        scaled = ({32'd0, la - lr} * DB_PER_OCTAVE + (64'd1 << 23)) >> 24;
        if (scaled > LEVEL_CEILING) scaled = LEVEL_CEILING;
        return scaled[LEVEL_W-1:0];
    endfunction

    function automatic void meter_reset();
        win_hi      = '0;
        win_lo      = '1;
        cal_total   = 0;
        cal_windows = 0;
        ref_q4      = REF_AT_RESET[REF_W-1:0];
    endfunction

    // advance the meter by one accepted item, giving its reading if any
    function automatic void predict_reading(input logic [SAMPLE_BITS-1:0] sample,
                                            input logic last, input t_mode mode,
                                            output bit produces, output meter_reading_t rd);
        logic [SAMPLE_BITS-1:0] raw;
        int unsigned            q;
        produces = 1'b0;
        rd       = '0;
        case (mode)
            MODE_CAL_END: begin
                if (cal_windows == 0) begin
                    q = REF_UNITY;
                end else begin
                    q = (cal_total * 16 + cal_windows / 2) / cal_windows;
                    if (q < REF_UNITY) q = REF_UNITY;
                    if (q > 32'hFFFF) q = 32'hFFFF;
                end
                ref_q4      = q[REF_W-1:0];
                cal_total   = 0;
                cal_windows = 0;
                produces    = 1'b1;
                rd          = '{amplitude: '0, level_db: '0, reference: ref_q4,
                                is_calibration: 1'b1};
            end
            MODE_NONE: begin
            end
            default: begin
                if (sample > win_hi) win_hi = sample;
                if (sample < win_lo) win_lo = sample;
                if (last) begin
                    raw = (win_hi >= win_lo) ? win_hi - win_lo : '0;
                    win_hi = '0;
                    win_lo = '1;
                    if (mode == MODE_CAL_ADD) begin
                        // calibration store full: window is dropped
                        if (cal_windows < CAL_WINDOW_CAP) begin
                            cal_total += raw;
                            cal_windows++;
                        end
                    end else begin
                        if (raw == '0) raw = SAMPLE_BITS'(1);
                        produces = 1'b1;
                        rd = '{amplitude: raw, level_db: db_level(raw, ref_q4),
                               reference: ref_q4, is_calibration: 1'b0};
                    end
                end
            end
        endcase
    endfunction

    function automatic void table_row(input logic [SAMPLE_BITS-1:0] sample, input logic last,
                                      input t_mode mode, input bit typed,
                                      input meter_reading_t want);
        stim_row_t row;
        row.sample = sample;
        row.last   = last;
        row.mode   = mode;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // offer one item, wait for acceptance, then record what it should give
    task automatic send_item(input logic [SAMPLE_BITS-1:0] sample, input logic last,
                             input t_mode mode, input bit typed, input meter_reading_t want);
        bit             produces;
        meter_reading_t rd;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sample         <= sample;
        i_last_in_window <= last;
        i_mode           <= mode;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_reading(sample, last, mode, produces, rd);
        if (produces) pending_readings.push_back(typed ? want : rd);
        if (mode != MODE_NONE) items_sent++;
    endtask

    // one window of random content, with some noise and stray modes mixed in
    task automatic send_random_window();
        int unsigned            len;
        int unsigned            spread;
        int unsigned            pick;
        t_mode                  wmode;
        t_mode                  m;
        logic [SAMPLE_BITS-1:0] base;
        logic [SAMPLE_BITS-1:0] s;
        wmode = ($urandom_range(0, 99) < 65) ? MODE_MEASURE : MODE_CAL_ADD;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        base = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 2))
            0:       spread = 3;
            1:       spread = 63;
            default: spread = 4095;
        endcase
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_item(SAMPLE_BITS'($urandom), 1'($urandom), MODE_NONE, 1'b0, '0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) s = '0;
            else if (pick < 10) s = '1;
            else s = base + SAMPLE_BITS'($urandom_range(0, spread));
            m = ($urandom_range(0, 99) < 12) ? t_mode'($urandom_range(0, 1)) : wmode;
            send_item(s, k == len - 1, m, 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 10)
            send_item(SAMPLE_BITS'($urandom), 1'($urandom), MODE_CAL_END, 1'b0, '0);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD;
            i_ready         <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        meter_reading_t got;
        meter_reading_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{amplitude: o_amplitude, level_db: o_level_db, reference: o_reference,
                    is_calibration: o_is_calibration};
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item: amp %0d level %0d ref %0d cal %0d",
                             got.amplitude, got.level_db, got.reference, got.is_calibration);
            end else begin
                want = pending_readings.pop_front();
                if (got.amplitude !== want.amplitude || got.level_db !== want.level_db ||
                    got.reference !== want.reference ||
                    got.is_calibration !== want.is_calibration) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected amp %0d level %0d ref %0d cal %0d, %s",
                                 want.amplitude, want.level_db, want.reference,
                                 want.is_calibration,
                                 $sformatf("got amp %0d level %0d ref %0d cal %0d",
                                           got.amplitude, got.level_db, got.reference,
                                           got.is_calibration));
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned            fill_target;
        logic [SAMPLE_BITS-1:0] lo;
        meter_reading_t         none;
        none = '0;
        meter_reset();

        // directed rows: extremes, every mode, calibration corner cases
        table_row(12'd4095, 1'b1, MODE_CAL_END, 1'b1, '{12'd0, 15'd0, 16'd16, 1'b1});
        table_row(12'd0,    1'b1, MODE_MEASURE, 1'b1, '{12'd1, 15'd0, 16'd16, 1'b0});
        table_row(12'd4095, 1'b1, MODE_MEASURE, 1'b1, '{12'd1, 15'd0, 16'd16, 1'b0});
        table_row(12'd0,    1'b0, MODE_MEASURE, 1'b0, none);
        table_row(12'd4095, 1'b1, MODE_MEASURE, 1'b0, none);
        // mode three in the middle of a window is ignored
        table_row(12'd2048, 1'b0, MODE_MEASURE, 1'b0, none);
        table_row(12'd0,    1'b1, MODE_NONE,    1'b0, none);
        table_row(12'd2049, 1'b1, MODE_MEASURE, 1'b1, '{12'd1, 15'd0, 16'd16, 1'b0});
        // full-scale calibration window
        table_row(12'd0,    1'b0, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd4095, 1'b1, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd0,    1'b0, MODE_CAL_END, 1'b1, '{12'd0, 15'd0, 16'd65520, 1'b1});
        table_row(12'd0,    1'b0, MODE_MEASURE, 1'b0, none);
        table_row(12'd4095, 1'b1, MODE_MEASURE, 1'b1, '{12'd4095, 15'd0, 16'd65520, 1'b0});
        // zero-amplitude calibration floors the reference
        table_row(12'd5,    1'b1, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd4095, 1'b0, MODE_CAL_END, 1'b1, '{12'd0, 15'd0, 16'd16, 1'b1});
        // two small windows with an exact mean
        table_row(12'd10,   1'b0, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd13,   1'b1, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd7,    1'b0, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd8,    1'b1, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd0,    1'b1, MODE_CAL_END, 1'b1, '{12'd0, 15'd0, 16'd32, 1'b1});
        // mixed-mode window closed in measure mode
        table_row(12'd0,    1'b0, MODE_CAL_ADD, 1'b0, none);
        table_row(12'd4095, 1'b1, MODE_MEASURE, 1'b0, none);
        // finishing calibration leaves the open window alone
        table_row(12'd500,  1'b0, MODE_MEASURE, 1'b0, none);
        table_row(12'd123,  1'b1, MODE_CAL_END, 1'b1, '{12'd0, 15'd0, 16'd16, 1'b1});
        table_row(12'd600,  1'b1, MODE_MEASURE, 1'b0, none);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].sample, directed_rows[r].last, directed_rows[r].mode,
                      directed_rows[r].typed, directed_rows[r].want);

        // random windows: sender idles less than receiver
        while (items_sent < 80) send_random_window();

        // receiver idles less than sender
        tx_idle_pct = 48;
        rx_idle_pct <= 23;
        while (items_sent < 130) send_random_window();

        // no idling, with one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        long_hold_req <= 1'b1;
        while (items_sent < 180) send_random_window();

        // overfill the calibration store: empty windows, then wide ones across the cap
        send_item(SAMPLE_BITS'($urandom), 1'($urandom), MODE_CAL_END, 1'b0, none);
        for (int w = 0; w < CAL_FILL_WINDOWS; w++) begin
            if (w >= CAL_WINDOW_CAP - CAL_WIDE_WINDOWS) begin
                lo = SAMPLE_BITS'($urandom_range(0, 1023));
                send_item(lo, 1'b0, MODE_CAL_ADD, 1'b0, none);
                send_item(SAMPLE_BITS'($urandom_range(2048, 4095)), 1'b1, MODE_CAL_ADD,
                          1'b0, none);
            end else begin
                send_item(SAMPLE_BITS'($urandom), 1'b1, MODE_CAL_ADD, 1'b0, none);
            end
        end
        send_item(SAMPLE_BITS'($urandom), 1'($urandom), MODE_CAL_END, 1'b0, none);
        fill_target = items_sent + 10;
        while (items_sent < fill_target) send_random_window();
        i_valid <= 1'b0;

        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
